// ===== rtl/core/dss_pkg.sv =====
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants of the deadline slot scheduler.
// ----------------------------------------------------------------------------
package dss_pkg;

    // Slots are kept eight to a memory row.
    localparam int unsigned ROW_BITS  = 8;
    localparam int unsigned ROW_BIT_W = 3;

    localparam int unsigned TAG_W     = 8;
    localparam int unsigned DL_W      = 16;
    localparam int unsigned PROFIT_W  = 16;
    localparam int unsigned SLOT_W    = 7;
    localparam int unsigned SUM_W     = 23;
    localparam int unsigned TOTAL_W   = 22;

    localparam logic [SUM_W-1:0] SUM_MAX   = 23'h7FFFFF;
    localparam logic [SUM_W-1:0] TOTAL_MAX = 23'h3FFFFF;

    typedef logic [ROW_BITS-1:0] row_t;

    // Outcome of the search across one row of the slot map.
    typedef struct packed {
        logic                 found;
        logic [ROW_BIT_W-1:0] pos;
    } search_res_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_DONE   = 3'b100
    } state_t;

endpackage

// ===== rtl/core/deadline_slot_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// deadline_slot_scheduler_unit
// Greedy job sequencing with deadlines: place each job in the latest free
// slot at or below its clamped deadline and keep a running profit total.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake           | Payload
//  --------+---------------------+---------------------------------------------
//  in      | in_valid / in_stall | first_job, job_tag, deadline, profit
//  out     | out_valid/out_stall | result_tag, accepted, slot_taken,
//          |                     | total_profit
//
//  A job reads k slot-map rows downwards from its deadline, where k runs
//  from 1 to ceil(NUM_SLOTS/8); a zero deadline reads no row at all.
//  The single read port of the slot-map RAM sets the pace: one row
//  of eight slots is examined per cycle, with each row's read issued ahead.
//  Reset clears the per-row valid flags at once; no clearing pass is needed,
//  and a first_job transaction clears them the same way.
//  The result register parts the channels: a stalled result holds while the
//  next job is accepted and searched, and only the hand-over waits.
//
module deadline_slot_scheduler_unit
    import dss_pkg::*;
#(
    parameter int unsigned NUM_SLOTS = 64
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic                first_job,
    input  logic [TAG_W-1:0]    job_tag,
    input  logic [DL_W-1:0]     deadline,
    input  logic [PROFIT_W-1:0] profit,

    output logic                out_valid,
    input  logic                out_stall,
    output logic [TAG_W-1:0]    result_tag,
    output logic                accepted,
    output logic [SLOT_W-1:0]   slot_taken,
    output logic [TOTAL_W-1:0]  total_profit
);

    localparam int unsigned ROWS  = (NUM_SLOTS + ROW_BITS - 1) / ROW_BITS;
    localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t              state_reg, state_next;
    logic [ROW_W-1:0]    row_reg;
    row_t                mask_reg;
    logic [ROWS-1:0]     row_valid_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic [PROFIT_W-1:0] profit_reg;
    logic                res_acc_reg;
    logic [SLOT_W-1:0]   res_slot_reg;

    logic                out_valid_reg;
    logic [TAG_W-1:0]    result_tag_reg;
    logic                accepted_reg;
    logic [SLOT_W-1:0]   slot_taken_reg;
    logic [TOTAL_W-1:0]  total_profit_reg;

    // ------------------------------------------------------------------
    // Datapath signals
    // ------------------------------------------------------------------
    logic                in_fire;
    logic                out_free;
    logic [DL_W-1:0]     dl_clamped;
    logic [DL_W-1:0]     dl_m1;
    logic [ROW_W-1:0]    start_row;
    row_t                start_mask;
    row_t                rd_data;
    row_t                row_used;
    search_res_t         sres;
    logic                ram_wr_en;
    row_t                ram_wr_data;
    logic                ram_rd_en;
    logic [ROW_W-1:0]    ram_rd_addr;
    logic                search_found;
    logic                search_more;
    logic [DL_W-1:0]     slot_wide;
    logic [SUM_W:0]      sum_add;
    logic [SUM_W-1:0]    sum_sat;

    assign in_fire  = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // Clamp the deadline to the slot count, then split slot-1 into row and bit.
    assign dl_clamped = (deadline > DL_W'(NUM_SLOTS)) ? DL_W'(NUM_SLOTS) : deadline;
    assign dl_m1      = dl_clamped - DL_W'(1);
    assign start_row  = dl_m1[ROW_W+ROW_BIT_W-1:ROW_BIT_W];
    assign start_mask = row_t'({ROW_BITS{1'b1}}) >> (ROW_BIT_W'(ROW_BITS - 1)
                        - dl_m1[ROW_BIT_W-1:0]);

    // A row that has not been written since the last clear reads as all free.
    assign row_used = row_valid_reg[row_reg] ? rd_data : '0;

    dss_row_search u_search (
        .used (row_used),
        .mask (mask_reg),
        .res  (sres)
    );

    assign search_found = (state_reg == ST_SEARCH) && sres.found;
    assign search_more  = (state_reg == ST_SEARCH) && !sres.found && (row_reg != '0);

    // Read-modify-write of the slot map: mark the chosen slot used.
    assign ram_wr_en   = search_found;
    assign ram_wr_data = row_used | (row_t'(1) << sres.pos);

    // Issue the first read on acceptance, then walk down a row per cycle.
    always_comb
    begin
        ram_rd_en   = 1'b0;
        ram_rd_addr = start_row;
        if (search_more)
        begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = row_reg - ROW_W'(1);
        end
        else if (in_fire && (dl_clamped != '0))
        begin
            ram_rd_en = 1'b1;
        end
    end

    dss_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (ROWS)
    ) u_slot_map (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (row_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (rd_data)
    );

    assign slot_wide = DL_W'({row_reg, sres.pos}) + DL_W'(1);
    assign sum_add   = {1'b0, sum_reg} + (SUM_W + 1)'(profit_reg);
    assign sum_sat   = (sum_add > (SUM_W + 1)'(SUM_MAX)) ? SUM_MAX : sum_add[SUM_W-1:0];

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (dl_clamped == '0) ? ST_DONE : ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (!search_more)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_valid_reg <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Clear the set: drop every row and the running total.
            if (in_fire && first_job)
            begin
                row_valid_reg <= '0;
                sum_reg       <= '0;
            end
            else if (search_found)
            begin
                row_valid_reg[row_reg] <= 1'b1;
                sum_reg                <= sum_sat;
            end

            if ((state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the job in flight and of the result register.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            tag_reg      <= job_tag;
            profit_reg   <= profit;
            row_reg      <= start_row;
            mask_reg     <= start_mask;
            res_acc_reg  <= 1'b0;
            res_slot_reg <= '0;
        end
        else if (search_more)
        begin
            row_reg  <= row_reg - ROW_W'(1);
            mask_reg <= row_t'({ROW_BITS{1'b1}});
        end
        else if (search_found)
        begin
            res_acc_reg  <= 1'b1;
            res_slot_reg <= slot_wide[SLOT_W-1:0];
        end

        if ((state_reg == ST_DONE) && out_free)
        begin
            result_tag_reg   <= tag_reg;
            accepted_reg     <= res_acc_reg;
            slot_taken_reg   <= res_slot_reg;
            total_profit_reg <= (sum_reg > TOTAL_MAX) ? TOTAL_MAX[TOTAL_W-1:0]
                                                      : sum_reg[TOTAL_W-1:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_tag   = result_tag_reg;
    assign accepted     = accepted_reg;
    assign slot_taken   = slot_taken_reg;
    assign total_profit = total_profit_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_write_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (state_reg == ST_SEARCH))
        else $error("slot map written outside search");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_SEARCH || state_reg == ST_DONE))
        else $error("accepted job did not start");

    a_reject_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !accepted) |-> (slot_taken == '0))
        else $error("rejected job reports a slot");

endmodule

// ===== rtl/core/dss_ram.sv =====
// ----------------------------------------------------------------------------
// dss_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dss_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/dss_row_search.sv =====
// ----------------------------------------------------------------------------
// dss_row_search
// Find the highest free slot of one slot-map row within a search mask.
// ----------------------------------------------------------------------------
module dss_row_search
    import dss_pkg::*;
(
    input  row_t        used,
    input  row_t        mask,
    output search_res_t res
);

    row_t free_bits;

    assign free_bits = ~used & mask;

    // Scan upwards so that the highest free bit wins.
    always_comb
    begin
        res.found = 1'b0;
        res.pos   = '0;
        for (int i = 0; i < ROW_BITS; i++)
        begin
            if (free_bits[i])
            begin
                res.found = 1'b1;
                res.pos   = ROW_BIT_W'(i);
            end
        end
    end

endmodule
